// ===== rtl/core/stq_pkg.sv =====
`default_nettype none

package stq_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_LIST = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
    localparam logic [OP_W-1:0] OP_POP  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_PEEK_EMPTY = 3'd1;
    localparam logic [ST_W-1:0] ST_POP_EMPTY  = 3'd2;
    localparam logic [ST_W-1:0] ST_SWAP_SHORT = 3'd3;
    localparam logic [ST_W-1:0] ST_PUSH_FULL  = 3'd4;

    typedef struct packed {
        logic                     load;
        logic signed [DATA_W-1:0] value;
        logic                     value_valid;
        logic [ST_W-1:0]          status;
        logic                     last;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/stq_in_if.sv =====
`default_nettype none

interface stq_in_if;
    import stq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stq_out_if.sv =====
`default_nettype none

interface stq_out_if;
    import stq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     value_valid;
    logic [ST_W-1:0]          status;
    logic                     last;

    modport source (output valid, output value, output value_valid, output status,
                    output last, input ready);
    modport sink   (input valid, input value, input value_valid, input status,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stq_ram.sv =====
`default_nettype none

module stq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/stq_ctrl.sv =====
`default_nettype none

module stq_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_queue_mode,
    input  wire logic                             i_out_free,
    stq_in_if.sink                                i_in,
    output stq_pkg::t_res                         o_res,
    output logic                                  o_ram_we,
    output logic [AW-1:0]                         o_ram_waddr,
    output logic [stq_pkg::DATA_W-1:0]            o_ram_wdata,
    output logic                                  o_ram_re,
    output logic [AW-1:0]                         o_ram_raddr,
    input  wire logic [stq_pkg::DATA_W-1:0]       i_ram_rdata
);
    import stq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PEEK   = 3'd1;
    localparam logic [2:0] S_SWAP_A = 3'd2;
    localparam logic [2:0] S_SWAP_B = 3'd3;
    localparam logic [2:0] S_SWAP_W = 3'd4;
    localparam logic [2:0] S_LIST   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_top, n_top;
    logic [CW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W-1:0] r_hold, n_hold;

    logic          accept;
    logic          is_empty;
    logic          is_full;
    logic          list_last;
    logic [AW-1:0] top_inc;
    logic [AW-1:0] top_dec;
    logic [AW-1:0] ptr_inc;
    logic [AW-1:0] tail_slot;
    logic [SW-1:0] tail_sum;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        r = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
        return r;
    endfunction

    assign top_inc   = wrap_inc(r_top);
    assign ptr_inc   = wrap_inc(r_ptr);
    assign top_dec   = (r_top == '0) ? AW'(DEPTH - 1) : r_top - AW'(1);
    assign tail_sum  = SW'(r_top) + SW'(r_fill);
    assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                : AW'(tail_sum);
    assign is_empty  = (r_fill == '0);
    assign is_full   = (r_fill == CW'(DEPTH));
    assign list_last = ((r_cnt + CW'(1)) == r_fill);

    assign i_in.ready = (r_state == S_IDLE) && i_out_free;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_hold      = r_hold;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_top;
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_top;
        o_res       = '0;
        o_res.last  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.op)
                        OP_PUSH: begin
                            o_res.load = 1'b1;
                            if (is_full) begin
                                o_res.status = ST_PUSH_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_wdata = i_in.push_value;
                                n_fill      = r_fill + CW'(1);
                                if (i_queue_mode) begin
                                    o_ram_waddr = tail_slot;
                                end else begin
                                    o_ram_waddr = top_dec;
                                    n_top       = top_dec;
                                end
                            end
                        end
                        OP_LIST: begin
                            if (is_empty) begin
                                o_res.load = 1'b1;
                            end else begin
                                o_ram_re = 1'b1;
                                n_ptr    = top_inc;
                                n_cnt    = '0;
                                n_state  = S_LIST;
                            end
                        end
                        OP_PEEK: begin
                            if (is_empty) begin
                                o_res.load   = 1'b1;
                                o_res.status = ST_PEEK_EMPTY;
                            end else begin
                                o_ram_re = 1'b1;
                                n_state  = S_PEEK;
                            end
                        end
                        OP_POP: begin
                            o_res.load = 1'b1;
                            if (is_empty) begin
                                o_res.status = ST_POP_EMPTY;
                            end else begin
                                n_top  = top_inc;
                                n_fill = r_fill - CW'(1);
                            end
                        end
                        OP_SWAP: begin
                            if (r_fill < CW'(2)) begin
                                o_res.load   = 1'b1;
                                o_res.status = ST_SWAP_SHORT;
                            end else begin
                                o_ram_re = 1'b1;
                                n_state  = S_SWAP_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PEEK: begin
                if (i_out_free) begin
                    o_res.load        = 1'b1;
                    o_res.value       = i_ram_rdata;
                    o_res.value_valid = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SWAP_A: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = top_inc;
                n_hold      = i_ram_rdata;
                n_state     = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = i_ram_rdata;
                n_state     = S_SWAP_W;
            end
            S_SWAP_W: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = top_inc;
                o_ram_wdata = r_hold;
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_out_free) begin
                    o_res.load        = 1'b1;
                    o_res.value       = i_ram_rdata;
                    o_res.value_valid = 1'b1;
                    o_res.last        = list_last;
                    n_cnt             = r_cnt + CW'(1);
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_ptr;
                        n_ptr       = ptr_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_fill  <= n_fill;
        end
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_hold <= n_hold;
    end

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above depth");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_we && o_ram_re))
        else $error("read and write in the same cycle");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

    a_list_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_cnt < r_fill))
        else $error("list walk past fill count");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.op == OP_POP && !is_empty) |=> (r_fill == $past(r_fill) - CW'(1)))
        else $error("pop did not shrink the store");

endmodule

`default_nettype wire

// ===== rtl/core/stack_queue_engine.sv =====
`default_nettype none

// Channel   Dir  Fields                              Handshake
// i_in      in   op, push_value                      valid/ready
// o_out     out  value, value_valid, status, last    valid/ready
// i_cfg_*   in   queue_mode                          write enable, no wait
//
// Push and pop: result registered at accept. Unknown ops: accepted, no result.
// Peek: read, then result. Swap: two reads through the single read port, two writes.
// List all: a result per entry, one per cycle from the read port unless o_out stalls.
// Synchronous active-low reset clears top, fill count and mode; store is not cleared.
// A stall on o_out holds the current result and pauses any walk in progress.

module stack_queue_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data,
    stq_in_if.sink    i_in,
    stq_out_if.source o_out
);
    import stq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              r_queue_mode;
    logic              r_out_valid;
    t_res              r_out;
    t_res              res;
    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign out_free = !r_out_valid || o_out.ready;

    stq_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_queue_mode(r_queue_mode),
        .i_out_free  (out_free),
        .i_in        (i_in),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    stq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_mode <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_queue_mode <= i_cfg_data;
            end
            if (res.load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res.load) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.value       = r_out.value;
    assign o_out.value_valid = r_out.value_valid;
    assign o_out.status      = r_out.status;
    assign o_out.last        = r_out.last;

endmodule

`default_nettype wire

// ===== verif/stq_checker.sv =====
`timescale 1ns / 100ps

module stq_checker #(
    parameter int DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data,
    stq_in_if         in_ch,
    stq_out_if        out_ch,
    output int        o_pending,
    output int        o_fail_count
);
    import stq_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     value_valid;
        logic [ST_W-1:0]          status;
        logic                     last;
    } t_result;

    logic signed [DATA_W-1:0] store [DEPTH];
    int                       head;
    int                       fill;
    logic                     queue_mode;
    t_result                  expected_q [$];
    int                       fails = 0;

    function automatic void add_expected(logic signed [DATA_W-1:0] value, logic value_valid,
                                         logic [ST_W-1:0] status, logic last);
        t_result r;
        r.value       = value;
        r.value_valid = value_valid;
        r.status      = status;
        r.last        = last;
        expected_q.push_back(r);
    endfunction

    task automatic predict_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] push_value);
        int                       slot_a;
        int                       slot_b;
        logic signed [DATA_W-1:0] held;
        case (op)
            OP_PUSH: begin
                if (fill >= DEPTH) begin
                    add_expected('0, 1'b0, ST_PUSH_FULL, 1'b1);
                end else begin
                    if (queue_mode) begin
                        store[(head + fill) % DEPTH] = push_value;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        store[head] = push_value;
                    end
                    fill++;
                    add_expected('0, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_LIST: begin
                if (fill == 0) begin
                    add_expected('0, 1'b0, ST_OK, 1'b1);
                end else begin
                    for (int k = 0; k < fill; k++) begin
                        add_expected(store[(head + k) % DEPTH], 1'b1, ST_OK, k == fill - 1);
                    end
                end
            end
            OP_PEEK: begin
                if (fill == 0) begin
                    add_expected('0, 1'b0, ST_PEEK_EMPTY, 1'b1);
                end else begin
                    add_expected(store[head], 1'b1, ST_OK, 1'b1);
                end
            end
            OP_POP: begin
                if (fill == 0) begin
                    add_expected('0, 1'b0, ST_POP_EMPTY, 1'b1);
                end else begin
                    head = (head + 1) % DEPTH;
                    fill--;
                    add_expected('0, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_SWAP: begin
                if (fill < 2) begin
                    add_expected('0, 1'b0, ST_SWAP_SHORT, 1'b1);
                end else begin
                    slot_a = head;
                    slot_b = (head + 1) % DEPTH;
                    held = store[slot_a];
                    store[slot_a] = store[slot_b];
                    store[slot_b] = held;
                    add_expected('0, 1'b0, ST_OK, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        t_result exp_r;
        if (expected_q.size() == 0) begin
            $error("result with no item waiting: value %0d status %0d last %0d",
                   out_ch.value, out_ch.status, out_ch.last);
            fails++;
        end else begin
            exp_r = expected_q.pop_front();
            if (out_ch.value !== exp_r.value) begin
                $error("value: expected %0d, actual %0d", exp_r.value, out_ch.value);
                fails++;
            end
            if (out_ch.value_valid !== exp_r.value_valid) begin
                $error("value_valid: expected %0d, actual %0d",
                       exp_r.value_valid, out_ch.value_valid);
                fails++;
            end
            if (out_ch.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, out_ch.status);
                fails++;
            end
            if (out_ch.last !== exp_r.last) begin
                $error("last: expected %0d, actual %0d", exp_r.last, out_ch.last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head       = 0;
            fill       = 0;
            queue_mode = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                queue_mode = i_cfg_data;
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_item(in_ch.op, in_ch.push_value);
            end
            if (out_ch.valid && out_ch.ready) begin
                check_result();
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import stq_pkg::*;

    localparam int STORE_DEPTH     = 64;
    localparam int RESET_CYCLES    = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;
    int   pending;
    int   fail_count;
    int   idle_cycles = 0;
    bit   idle_on = 1'b1;
    bit   hold_off_req = 1'b0;

    stq_in_if  in_ch ();
    stq_out_if out_ch ();

    stack_queue_engine #(
        .DEPTH(STORE_DEPTH)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    stq_checker #(
        .DEPTH(STORE_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return MAX_VALUE;
            1:       return MIN_VALUE;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_PUSH;
        if (r < 45) return OP_LIST;
        if (r < 60) return OP_PEEK;
        if (r < 85) return OP_POP;
        if (r < 97) return OP_SWAP;
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.push_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic mode);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random(int count);
        repeat (count) send_item(rand_op(), rand_value());
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= OP_PUSH;
        in_ch.push_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        send_item(OP_PEEK, '0);
        send_item(OP_POP, '0);
        send_item(OP_SWAP, '0);
        send_item(OP_LIST, '0);
        send_item(OP_PUSH, MAX_VALUE);
        send_item(OP_SWAP, '0);
        send_item(OP_PEEK, '0);
        send_item(OP_PUSH, MIN_VALUE);
        send_item(OP_PUSH, -1);
        send_item(OP_PUSH, '0);
        send_item(OP_UNUSED_LO, 32'sh5555_AAAA);
        send_item(OP_UNUSED_LO + 3'd1, '0);
        send_item(OP_UNUSED_HI, -1);
        send_item(OP_LIST, '0);
        send_item(OP_SWAP, '0);
        send_item(OP_PEEK, '0);
        send_item(OP_LIST, '0);
        repeat (4) send_item(OP_POP, '0);
        send_item(OP_POP, '0);
        send_item(OP_LIST, '0);

        // hold the result side while the store fills past its depth
        hold_off_req = 1'b1;
        repeat (STORE_DEPTH + 2) send_item(OP_PUSH, rand_value());
        send_item(OP_LIST, '0);
        send_item(OP_PEEK, '0);

        write_mode(1'b1);
        send_item(OP_PUSH, MAX_VALUE);
        repeat (2) send_item(OP_POP, '0);
        send_item(OP_PUSH, MIN_VALUE);
        send_item(OP_PUSH, MAX_VALUE);
        send_item(OP_LIST, '0);
        send_item(OP_SWAP, '0);
        send_item(OP_PEEK, '0);
        run_random(12);

        write_mode(1'b0);
        run_random(10);

        write_mode(1'b1);
        idle_on = 1'b0;
        run_random(10);

        wait_drained();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/stq_pkg.sv
rtl/core/stq_in_if.sv
rtl/core/stq_out_if.sv
rtl/core/stq_ram.sv
rtl/core/stq_ctrl.sv
rtl/core/stack_queue_engine.sv
verif/stq_checker.sv
verif/testbench.sv
